### sv/lwf_pkg.sv
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types and constants of the lidar wall-follow steering block.
// ----------------------------------------------------------------------------
package lwf_pkg;

    localparam int SCAN_POINTS_DEFAULT = 512;

    localparam int RANGE_W   = 16;
    localparam int WIN_W     = 9;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;
    localparam int LIN_W     = 10;
    localparam int TURN_W    = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // divider sizing: largest dividend is 1500 * 65535 < 2**27
    localparam int NUM_W = 27;
    localparam int DEN_W = 17;
    localparam int DCNT_W = 5;

    localparam logic [RANGE_W-1:0] NO_RETURN = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_START    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_END      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_END      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_STOP_MM   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_TARGET_MM = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_BAND_MM   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_SLOW_MM  = 4'd7;

    // register reset values
    localparam logic [WIN_W-1:0]   FRONT_START_RST    = 9'd492;
    localparam logic [WIN_W-1:0]   FRONT_END_RST      = 9'd20;
    localparam logic [WIN_W-1:0]   RIGHT_START_RST    = 9'd422;
    localparam logic [WIN_W-1:0]   RIGHT_END_RST      = 9'd452;
    localparam logic [RANGE_W-1:0] SEEK_STOP_MM_RST   = 16'd600;
    localparam logic [RANGE_W-1:0] WALL_TARGET_MM_RST = 16'd300;
    localparam logic [RANGE_W-1:0] WALL_BAND_MM_RST   = 16'd20;
    localparam logic [RANGE_W-1:0] FRONT_SLOW_MM_RST  = 16'd1000;

    // drive constants, mm/s and mrad/s
    localparam logic [LIN_W-1:0]  SEEK_SPEED  = 10'd400;
    localparam logic [LIN_W-1:0]  CRUISE_SPEED = 10'd800;
    localparam logic [NUM_W-1:0]  K_LIN       = 27'd800;
    localparam logic [NUM_W-1:0]  K_TURN_SLOW = 27'd1500;
    localparam logic [NUM_W-1:0]  K_TURN_WALL = 27'd250;
    localparam logic [TURN_W-1:0] TURN_MIN    = 16'h8000;
    localparam logic [NUM_W-1:0]  TURN_MIN_MAG = 27'd32768;

    typedef struct packed {
        logic [WIN_W-1:0] front_start;
        logic [WIN_W-1:0] front_end;
        logic [WIN_W-1:0] right_start;
        logic [WIN_W-1:0] right_end;
    } win_cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] seek_stop_mm;
        logic [RANGE_W-1:0] wall_target_mm;
        logic [RANGE_W-1:0] wall_band_mm;
        logic [RANGE_W-1:0] front_slow_mm;
    } ctl_cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] front_min;
        logic [RANGE_W-1:0] right_min;
    } scan_min_t;

endpackage

### sv/lwf_if.sv
// ----------------------------------------------------------------------------
// lwf interfaces
// Valid/ready channels: range samples in, drive commands out, register writes.
// ----------------------------------------------------------------------------
interface lwf_sample_if;
    logic                         valid;
    logic                         ready;
    logic [lwf_pkg::RANGE_W-1:0]  range_mm;
    logic                         last_sample;

    modport source (output valid, range_mm, last_sample, input ready);
    modport sink   (input valid, range_mm, last_sample, output ready);
endinterface

interface lwf_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [lwf_pkg::LIN_W-1:0]         linear_speed;
    logic signed [lwf_pkg::TURN_W-1:0] turn_rate;
    logic                              wall_acquired;

    modport source (output valid, linear_speed, turn_rate, wall_acquired, input ready);
    modport sink   (input valid, linear_speed, turn_rate, wall_acquired, output ready);
endinterface

interface lwf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lwf_pkg::CFG_IDX_W-1:0] index;
    logic [lwf_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/lwf_front.sv
// ----------------------------------------------------------------------------
// lwf_front
// Sample intake: counts the index, keeps the arc minima, queues them per scan.
// ----------------------------------------------------------------------------
module lwf_front #(
    parameter int SCAN_POINTS = lwf_pkg::SCAN_POINTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lwf_sample_if.sink            sample,
    input  lwf_pkg::win_cfg_t     win,
    input  logic                  q_full,
    output logic                  q_push,
    output lwf_pkg::scan_min_t    q_data
);

    localparam int IDX_W = $clog2(SCAN_POINTS);
    localparam int CMP_W = (IDX_W > lwf_pkg::WIN_W) ? IDX_W : lwf_pkg::WIN_W;

    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [lwf_pkg::RANGE_W-1:0] fmin_reg, fmin_next;
    logic [lwf_pkg::RANGE_W-1:0] rmin_reg, rmin_next;
    logic                        xfer;
    logic                        in_front, in_right;
    logic [lwf_pkg::RANGE_W-1:0] fmin_upd, rmin_upd;

    // start >= end means the window wraps past index zero
    function automatic logic in_window(input logic [CMP_W-1:0] i,
                                       input logic [CMP_W-1:0] s,
                                       input logic [CMP_W-1:0] e);
        logic r;
        if (s < e)
            r = (i >= s) && (i <= e);
        else
            r = (i >= s) || (i <= e);
        return r;
    endfunction

    assign sample.ready = !q_full;
    assign xfer         = sample.valid && sample.ready;

    always_comb
    begin
        in_front = in_window(CMP_W'(idx_reg), CMP_W'(win.front_start), CMP_W'(win.front_end));
        in_right = in_window(CMP_W'(idx_reg), CMP_W'(win.right_start), CMP_W'(win.right_end));
        fmin_upd = (in_front && sample.range_mm < fmin_reg) ? sample.range_mm : fmin_reg;
        rmin_upd = (in_right && sample.range_mm < rmin_reg) ? sample.range_mm : rmin_reg;

        idx_next  = idx_reg;
        fmin_next = fmin_reg;
        rmin_next = rmin_reg;
        if (xfer)
        begin
            if (sample.last_sample)
            begin
                idx_next  = '0;
                fmin_next = lwf_pkg::NO_RETURN;
                rmin_next = lwf_pkg::NO_RETURN;
            end
            else
            begin
                idx_next  = (idx_reg == IDX_W'(SCAN_POINTS - 1)) ? '0 : idx_reg + 1'b1;
                fmin_next = fmin_upd;
                rmin_next = rmin_upd;
            end
        end
    end

    assign q_push           = xfer && sample.last_sample;
    assign q_data.front_min = fmin_upd;
    assign q_data.right_min = rmin_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            fmin_reg <= lwf_pkg::NO_RETURN;
            rmin_reg <= lwf_pkg::NO_RETURN;
        end
        else
        begin
            idx_reg  <= idx_next;
            fmin_reg <= fmin_next;
            rmin_reg <= rmin_next;
        end
    end

endmodule

### sv/lwf_queue.sv
// ----------------------------------------------------------------------------
// lwf_queue
// Short FIFO of per-scan minima between the intake and the command engine.
// ----------------------------------------------------------------------------
module lwf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lwf_pkg::scan_min_t  push_data,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output lwf_pkg::scan_min_t  pop_data
);

    lwf_pkg::scan_min_t                mem [lwf_pkg::QUEUE_DEPTH];
    logic [lwf_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [lwf_pkg::QCNT_W-1:0]        cnt_reg;
    logic                              do_push, do_pop;

    assign full      = (cnt_reg == lwf_pkg::QCNT_W'(lwf_pkg::QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### sv/lwf_back.sv
// ----------------------------------------------------------------------------
// lwf_back
// Command engine: seek/follow rules, shared shift-subtract divider, output reg.
// ----------------------------------------------------------------------------
module lwf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lwf_pkg::ctl_cfg_t   ctl,
    input  logic                q_valid,
    input  lwf_pkg::scan_min_t  q_data,
    output logic                q_pop,
    lwf_cmd_if.source           cmd
);

    localparam int NW = lwf_pkg::NUM_W;
    localparam int DW = lwf_pkg::DEN_W;
    localparam int RW = lwf_pkg::RANGE_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    localparam logic [1:0] OP_LIN      = 2'd0;
    localparam logic [1:0] OP_TURN_POS = 2'd1;
    localparam logic [1:0] OP_TURN_NEG = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   op_reg, op_next;
    logic                         seeking_reg, seeking_next;
    logic [RW-1:0]                fmin_reg, fmin_next;
    logic [RW-1:0]                rmin_reg, rmin_next;
    logic [NW-1:0]                quo_reg, quo_next;
    logic [DW-1:0]                den_reg, den_next;
    logic [DW-1:0]                rem_reg, rem_next;
    logic [lwf_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [lwf_pkg::LIN_W-1:0]    lin_reg, lin_next;
    logic [lwf_pkg::TURN_W-1:0]   turn_reg, turn_next;
    logic                         found_reg, found_next;
    logic                         out_valid_reg, out_valid_next;
    logic [lwf_pkg::LIN_W-1:0]    out_lin_reg, out_lin_next;
    logic [lwf_pkg::TURN_W-1:0]   out_turn_reg, out_turn_next;
    logic                         out_found_reg, out_found_next;

    logic [DW:0]                  rem_sh, rem_try;
    logic [RW:0]                  hi;
    logic [RW-1:0]                lo;
    logic                         lo_pos;
    logic                         out_free;
    logic                         div_last;

    assign out_free = !out_valid_reg || cmd.ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign div_last = (cnt_reg == lwf_pkg::DCNT_W'(NW - 1));

    // one quotient bit per cycle
    assign rem_sh  = {rem_reg, quo_reg[NW-1]};
    assign rem_try = rem_sh - {1'b0, den_reg};

    assign hi     = {1'b0, ctl.wall_target_mm} + {1'b0, ctl.wall_band_mm};
    assign lo     = ctl.wall_target_mm - ctl.wall_band_mm;
    assign lo_pos = ctl.wall_target_mm > ctl.wall_band_mm;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        seeking_next   = seeking_reg;
        fmin_next      = fmin_reg;
        rmin_next      = rmin_reg;
        quo_next       = quo_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        lin_next       = lin_reg;
        turn_next      = turn_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_lin_next   = out_lin_reg;
        out_turn_next  = out_turn_reg;
        out_found_next = out_found_reg;

        if (out_valid_reg && cmd.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    fmin_next  = q_data.front_min;
                    rmin_next  = q_data.right_min;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                lin_next   = lwf_pkg::CRUISE_SPEED;
                turn_next  = '0;
                found_next = 1'b0;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_OUT;
                priority if (seeking_reg)
                begin
                    if (fmin_reg < ctl.seek_stop_mm)
                    begin
                        lin_next     = '0;
                        found_next   = 1'b1;
                        seeking_next = 1'b0;
                    end
                    else
                        lin_next = lwf_pkg::SEEK_SPEED;
                end
                else if (fmin_reg < ctl.front_slow_mm)
                begin
                    quo_next   = lwf_pkg::K_LIN * NW'(fmin_reg);
                    den_next   = DW'(ctl.front_slow_mm);
                    op_next    = OP_LIN;
                    state_next = ST_DIV;
                end
                else if (lo_pos && rmin_reg < lo)
                begin
                    quo_next   = lwf_pkg::K_TURN_WALL * NW'(lo - rmin_reg);
                    den_next   = DW'(lo);
                    op_next    = OP_TURN_POS;
                    state_next = ST_DIV;
                end
                else if (rmin_reg == lwf_pkg::NO_RETURN || {1'b0, rmin_reg} > hi)
                begin
                    if (rmin_reg == lwf_pkg::NO_RETURN || hi == '0)
                        turn_next = lwf_pkg::TURN_MIN;
                    else
                    begin
                        quo_next   = lwf_pkg::K_TURN_WALL * NW'(rmin_reg);
                        den_next   = hi;
                        op_next    = OP_TURN_NEG;
                        state_next = ST_DIV;
                    end
                end
                else
                    turn_next = '0;
            end
            ST_DIV:
            begin
                if (rem_try[DW])
                begin
                    rem_next = rem_sh[DW-1:0];
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                else
                begin
                    rem_next = rem_try[DW-1:0];
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    unique case (op_reg)
                        OP_LIN:
                        begin
                            // speed done, same divisor for the slow-down turn
                            lin_next = quo_next[lwf_pkg::LIN_W-1:0];
                            quo_next = lwf_pkg::K_TURN_SLOW
                                       * NW'(ctl.front_slow_mm - fmin_reg);
                            rem_next = '0;
                            cnt_next = '0;
                            op_next  = OP_TURN_POS;
                        end
                        OP_TURN_POS:
                        begin
                            turn_next  = quo_next[lwf_pkg::TURN_W-1:0];
                            state_next = ST_OUT;
                        end
                        OP_TURN_NEG:
                        begin
                            if (quo_next > lwf_pkg::TURN_MIN_MAG)
                                turn_next = lwf_pkg::TURN_MIN;
                            else
                                turn_next = '0 - quo_next[lwf_pkg::TURN_W-1:0];
                            state_next = ST_OUT;
                        end
                        default:
                            state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_lin_next   = lin_reg;
                    out_turn_next  = turn_reg;
                    out_found_next = found_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeking_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_LIN;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            seeking_reg   <= seeking_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmin_reg      <= fmin_next;
        rmin_reg      <= rmin_next;
        quo_reg       <= quo_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        lin_reg       <= lin_next;
        turn_reg      <= turn_next;
        found_reg     <= found_next;
        out_lin_reg   <= out_lin_next;
        out_turn_reg  <= out_turn_next;
        out_found_reg <= out_found_next;
    end

    assign cmd.valid         = out_valid_reg;
    assign cmd.linear_speed  = out_lin_reg;
    assign cmd.turn_rate     = out_turn_reg;
    assign cmd.wall_acquired = out_found_reg;

endmodule

### sv/lidar_wall_follow_steering_core.sv
// ----------------------------------------------------------------------------
// lidar_wall_follow_steering_core
// Wall-following steering controller driven by a streamed lidar scan.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one range per transfer (mm, 65535 = no return), last_sample
//            closes a scan. Index counting and arc minima run at one sample
//            per cycle; ready drops only while both queue slots hold scans.
//   cmd    : one drive command per scan, held in an output register until
//            the receiver takes it.
//   cfg    : register writes, always ready; write only while the block is idle.
// After the last sample the minima pass the queue, the idle, decide and
// any divide states, the output state and the output register. The front
// slow-down case runs two shift-subtract divisions on one divider.
// A queue of two scans sits between intake and command engine, so a stalled
// receiver only holds off samples once two further scans have closed.
// Reset: seek mode, index 0, minima at no return, registers at defaults,
// no command pending.
// ----------------------------------------------------------------------------
module lidar_wall_follow_steering_core #(
    parameter int SCAN_POINTS = lwf_pkg::SCAN_POINTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    lwf_sample_if.sink  sample,
    lwf_cmd_if.source   cmd,
    lwf_cfg_if.sink     cfg
);

    lwf_pkg::win_cfg_t   win_reg;
    lwf_pkg::ctl_cfg_t   ctl_reg;
    lwf_pkg::scan_min_t  push_data, pop_data;
    logic                q_push, q_full, q_pop, q_valid;
    logic                cfg_xfer;

    assign cfg.ready = 1'b1;
    assign cfg_xfer  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.front_start    <= lwf_pkg::FRONT_START_RST;
            win_reg.front_end      <= lwf_pkg::FRONT_END_RST;
            win_reg.right_start    <= lwf_pkg::RIGHT_START_RST;
            win_reg.right_end      <= lwf_pkg::RIGHT_END_RST;
            ctl_reg.seek_stop_mm   <= lwf_pkg::SEEK_STOP_MM_RST;
            ctl_reg.wall_target_mm <= lwf_pkg::WALL_TARGET_MM_RST;
            ctl_reg.wall_band_mm   <= lwf_pkg::WALL_BAND_MM_RST;
            ctl_reg.front_slow_mm  <= lwf_pkg::FRONT_SLOW_MM_RST;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg.index)
                lwf_pkg::REG_FRONT_START:    win_reg.front_start    <= cfg.data[lwf_pkg::WIN_W-1:0];
                lwf_pkg::REG_FRONT_END:      win_reg.front_end      <= cfg.data[lwf_pkg::WIN_W-1:0];
                lwf_pkg::REG_RIGHT_START:    win_reg.right_start    <= cfg.data[lwf_pkg::WIN_W-1:0];
                lwf_pkg::REG_RIGHT_END:      win_reg.right_end      <= cfg.data[lwf_pkg::WIN_W-1:0];
                lwf_pkg::REG_SEEK_STOP_MM:   ctl_reg.seek_stop_mm   <= cfg.data;
                lwf_pkg::REG_WALL_TARGET_MM: ctl_reg.wall_target_mm <= cfg.data;
                lwf_pkg::REG_WALL_BAND_MM:   ctl_reg.wall_band_mm   <= cfg.data;
                lwf_pkg::REG_FRONT_SLOW_MM:  ctl_reg.front_slow_mm  <= cfg.data;
                default: ;
            endcase
        end
    end

    lwf_front #(
        .SCAN_POINTS (SCAN_POINTS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .win    (win_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_data)
    );

    lwf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_data)
    );

    lwf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_reg),
        .q_valid (q_valid),
        .q_data  (pop_data),
        .q_pop   (q_pop),
        .cmd     (cmd)
    );

    // a closed scan must never be dropped at the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("scan minima pushed into a full queue");

    a_found_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.wall_acquired) |-> (cmd.linear_speed == '0 && cmd.turn_rate == '0))
        else $error("wall acquired command is not a stop");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid |-> (cmd.linear_speed <= lwf_pkg::CRUISE_SPEED))
        else $error("linear speed above cruise speed");

    // the command engine only pops what the queue holds
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from an empty queue");

endmodule
